// ===== rtl/dstwr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared types and constants of the two-way ranging time-of-flight block.
// ----------------------------------------------------------------------------
package dstwr_pkg;

    localparam int unsigned FLIGHT_BITS = 40;
    localparam int unsigned DIST_BITS   = 32;
    localparam int unsigned ADLY_BITS   = 16;
    localparam int unsigned MPT_BITS    = 32;
    localparam int unsigned CFG_IDX_BITS  = 1;
    localparam int unsigned CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_ANTENNA_DELAY = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_METRES_PER_TICK = 1'b1;

    localparam logic [MPT_BITS-1:0] MPT_RESET = 32'd20150973;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

endpackage : dstwr_pkg
`default_nettype wire

// ===== rtl/dstwr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_if
// Valid/ready channel interfaces: exchange input, result output, config write.
// ----------------------------------------------------------------------------
interface dstwr_in_if #(
    parameter int unsigned STAMP_BITS = 40
);
    logic                  valid;
    logic                  ready;
    logic [STAMP_BITS-1:0] poll_tx_time;
    logic [STAMP_BITS-1:0] response_rx_time;
    logic [STAMP_BITS-1:0] responder_reply;
    logic [STAMP_BITS-1:0] final_tx_time;
    logic [STAMP_BITS-1:0] responder_round;
    logic                  timed_out;

    modport source (output valid, poll_tx_time, response_rx_time, responder_reply,
                    final_tx_time, responder_round, timed_out, input ready);
    modport sink   (input valid, poll_tx_time, response_rx_time, responder_reply,
                    final_tx_time, responder_round, timed_out, output ready);
endinterface

interface dstwr_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] flight_ticks;
    logic [31:0] distance_q16;
    logic [1:0]  status;

    modport source (output valid, flight_ticks, distance_q16, status, input ready);
    modport sink   (input valid, flight_ticks, distance_q16, status, output ready);
endinterface

interface dstwr_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dstwr_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_div_cell
// One restoring-division cell: retires STEPS quotient bits per cycle while i_en is high on the
// remainder/numerator word it holds, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module dstwr_div_cell
    import dstwr_pkg::*;
#(
    parameter int unsigned NB    = 80,
    parameter int unsigned DB    = 42,
    parameter int unsigned STEPS = 4,
    parameter int unsigned QB    = 80
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DB:0]   i_rem,
    input  wire logic [NB-1:0] i_num,
    input  wire logic [DB-1:0] i_den,
    input  wire logic [QB-1:0] i_quo,
    input  wire logic [39:0]   i_tag,
    output logic               o_valid,
    output logic [DB:0]        o_rem,
    output logic [NB-1:0]      o_num,
    output logic [DB-1:0]      o_den,
    output logic [QB-1:0]      o_quo,
    output logic [39:0]        o_tag
);
    logic [DB:0]   n_rem;
    logic [NB-1:0] n_num;
    logic [QB-1:0] n_quo;
    logic [DB:0]   r_rem;
    logic [NB-1:0] r_num;
    logic [DB-1:0] r_den;
    logic [QB-1:0] r_quo;
    logic [39:0]   r_tag;
    logic          r_valid;

    // Shift in numerator bits, subtract where it fits
    always_comb begin
        logic [DB+1:0] t;
        n_rem = i_rem;
        n_num = i_num;
        n_quo = i_quo;
        for (int s = 0; s < STEPS; s++) begin
            t = {n_rem, n_num[NB-1]};
            n_num = {n_num[NB-2:0], 1'b0};
            if (t >= {2'b00, i_den}) begin
                t = t - {2'b00, i_den};
                n_quo = {n_quo[QB-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[QB-2:0], 1'b0};
            end
            n_rem = t[DB:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_den <= i_den;
            r_quo <= n_quo;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_tag   = r_tag;
endmodule : dstwr_div_cell
`default_nettype wire

// ===== rtl/ds_twr_time_of_flight_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight_top
// Double-sided two-way ranging: time of flight and distance from timestamps.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_in     in   five timestamps/intervals, timed_out
//  m_out    out  flight_ticks, distance_q16, status
//  s_cfg    in   register index, write data
//
//  One beat enters per cycle while the pipeline advances; the stages are
//  interval setup, product split, numerator compare, the row of division
//  cells at four quotient bits each, distance multiply and output register.
//  The whole pipeline advances only when the output register is free or
//  being drained, so a stall on m_out holds every stage. Reset clears valid
//  bits and loads the register defaults.
// ----------------------------------------------------------------------------
module ds_twr_time_of_flight_top
    import dstwr_pkg::*;
#(
    parameter int unsigned STAMP_BITS = 40
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dstwr_in_if.sink     s_in,
    dstwr_out_if.source  m_out,
    dstwr_cfg_if.sink    s_cfg
);
    localparam int unsigned SB    = STAMP_BITS;
    localparam int unsigned HB    = SB / 2;
    localparam int unsigned LB    = SB - HB;
    localparam int unsigned NB    = 2 * SB;
    localparam int unsigned DB    = SB + 2;
    localparam int unsigned STEPS = 4;
    localparam int unsigned NCELL = (NB + STEPS - 1) / STEPS;
    localparam int unsigned NPAD  = NCELL * STEPS;

    logic en;
    assign en = !m_out.valid || m_out.ready;

    // Configuration registers
    logic [ADLY_BITS-1:0] r_adly;
    logic [MPT_BITS-1:0]  r_mpt;
    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adly <= '0;
            r_mpt  <= MPT_RESET;
        end else if (s_cfg.valid) begin
            case (s_cfg.index)
                REG_ANTENNA_DELAY:   r_adly <= s_cfg.data[ADLY_BITS-1:0];
                REG_METRES_PER_TICK: r_mpt  <= s_cfg.data[MPT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign s_in.ready = en;
    logic acc;
    assign acc = s_in.valid && en;

    // Stage 1: intervals
    logic          r1_v, r1_to;
    logic [SB-1:0] r1_round1, r1_reply2, r1_reply1, r1_round2;
    logic [SB-1:0] adly_x;
    assign adly_x = SB'(r_adly);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= s_in.valid;
    end
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_to     <= s_in.timed_out;
            r1_round1 <= s_in.response_rx_time - s_in.poll_tx_time - adly_x;
            r1_reply2 <= s_in.final_tx_time + adly_x - s_in.response_rx_time;
            r1_reply1 <= s_in.responder_reply;
            r1_round2 <= s_in.responder_round;
        end
    end

    // Stage 2: partial products (halves), denominator
    logic          r2_v, r2_to;
    logic [2*LB-1:0] r2_a00, r2_b00;
    logic [HB+LB-1:0] r2_a01, r2_a10, r2_b01, r2_b10;
    logic [2*HB-1:0] r2_a11, r2_b11;
    logic [DB-1:0]   r2_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en)  r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_to  <= r1_to;
            r2_a00 <= r1_round1[LB-1:0] * r1_round2[LB-1:0];
            r2_a01 <= r1_round1[LB-1:0] * r1_round2[SB-1:LB];
            r2_a10 <= r1_round1[SB-1:LB] * r1_round2[LB-1:0];
            r2_a11 <= r1_round1[SB-1:LB] * r1_round2[SB-1:LB];
            r2_b00 <= r1_reply1[LB-1:0] * r1_reply2[LB-1:0];
            r2_b01 <= r1_reply1[LB-1:0] * r1_reply2[SB-1:LB];
            r2_b10 <= r1_reply1[SB-1:LB] * r1_reply2[LB-1:0];
            r2_b11 <= r1_reply1[SB-1:LB] * r1_reply2[SB-1:LB];
            r2_den <= DB'(r1_round1) + DB'(r1_round2) + DB'(r1_reply1) + DB'(r1_reply2);
        end
    end

    // Stage 3: sum products, compare and form numerator
    logic [NB-1:0] pa, pb;
    assign pa = NB'(r2_a00) + (NB'(r2_a01) << LB) + (NB'(r2_a10) << LB)
              + (NB'(r2_a11) << (2*LB));
    assign pb = NB'(r2_b00) + (NB'(r2_b01) << LB) + (NB'(r2_b10) << LB)
              + (NB'(r2_b11) << (2*LB));
    logic          r3_v;
    logic [1:0]    r3_st;
    logic [NB-1:0] r3_num;
    logic [DB-1:0] r3_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num <= pa - pb;
            r3_den <= (r2_den == '0) ? DB'(1) : r2_den;
            if (r2_to)                           r3_st <= ST_TIMEOUT;
            else if (pa < pb || r2_den == '0)    r3_st <= ST_INVALID;
            else                                 r3_st <= ST_OK;
        end
    end

    // Division row
    logic          c_v   [NCELL+1];
    logic [DB:0]   c_rem [NCELL+1];
    logic [NPAD-1:0] c_num [NCELL+1];
    logic [DB-1:0] c_den [NCELL+1];
    logic [SB-1:0] c_quo [NCELL+1];
    logic [39:0]   c_tag [NCELL+1];
    assign c_v[0]   = r3_v;
    assign c_rem[0] = '0;
    assign c_num[0] = NPAD'(r3_num);
    assign c_den[0] = r3_den;
    assign c_quo[0] = '0;
    assign c_tag[0] = 40'(r3_st);

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        dstwr_div_cell #(.NB(NPAD), .DB(DB), .STEPS(STEPS), .QB(SB)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(c_v[g]), .i_rem(c_rem[g]), .i_num(c_num[g]), .i_den(c_den[g]),
            .i_quo(c_quo[g]), .i_tag(c_tag[g]),
            .o_valid(c_v[g+1]), .o_rem(c_rem[g+1]), .o_num(c_num[g+1]),
            .o_den(c_den[g+1]), .o_quo(c_quo[g+1]), .o_tag(c_tag[g+1])
        );
    end

    // Distance multiply (flight time split in two halves)
    logic [SB-1:0] tof;
    logic [1:0]    st_d;
    assign st_d = c_tag[NCELL][1:0];
    assign tof  = (st_d == ST_OK) ? c_quo[NCELL] : '0;
    logic          r4_v;
    logic [1:0]    r4_st;
    logic [SB-1:0] r4_tof;
    logic [LB+MPT_BITS-1:0] r4_plo;
    logic [HB+MPT_BITS-1:0] r4_phi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en)  r4_v <= c_v[NCELL];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_st  <= st_d;
            r4_tof <= tof;
            r4_plo <= tof[LB-1:0] * r_mpt;
            r4_phi <= tof[SB-1:LB] * r_mpt;
        end
    end

    localparam int unsigned PB = SB + MPT_BITS;
    logic [PB-1:0] dist_prod;
    logic [FLIGHT_BITS-1:0] fl_sat;
    logic [DIST_BITS-1:0]   ds_sat;
    assign dist_prod = PB'(r4_plo) + (PB'(r4_phi) << LB);
    always_comb begin
        if (PB - 16 > DIST_BITS && (dist_prod >> (16 + DIST_BITS)) != '0)
            ds_sat = '1;
        else
            ds_sat = dist_prod[16 +: DIST_BITS];
        if (SB > FLIGHT_BITS && (r4_tof >> FLIGHT_BITS) != '0)
            fl_sat = '1;
        else
            fl_sat = FLIGHT_BITS'(r4_tof);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  m_out.valid <= 1'b0;
        else if (en)   m_out.valid <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            m_out.flight_ticks <= fl_sat;
            m_out.distance_q16 <= ds_sat;
            m_out.status       <= r4_st;
        end
    end

    // Error results carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.status != ST_OK |-> m_out.flight_ticks == '0
            && m_out.distance_q16 == '0)
        else $error("error result with nonzero payload");
    // Stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.flight_ticks))
        else $error("output changed under stall");
    // Ready follows output-side space
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready == (!m_out.valid || m_out.ready))
        else $error("input ready mismatch");
endmodule : ds_twr_time_of_flight_top
`default_nettype wire
